FILE: sv/ncomi_pkg.sv
// Shared constants, types and the sine table generator for the NCO mix and integrate unit.
package ncomi_pkg;

  localparam int TABLE_ENTRIES = 8192;
  localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
  localparam int QUARTER       = TABLE_ENTRIES / 4;
  localparam int SUM_WIDTH     = 48;
  localparam int OUT_W         = 48;
  localparam int PHASE_W       = 32;
  localparam int SAMPLE_W      = 8;
  localparam int ROM_W         = 15;
  localparam int DELTA_W       = 18;
  localparam int DSUM_W        = DELTA_W + 1;
  // every per-sample delta stays below 2^EDGE_W in magnitude
  localparam int EDGE_W        = DELTA_W - 1;

  // request queue between front and back, depth a power of two
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC = '0;

  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  localparam longint unsigned HALFPI_Q30 = 64'd1686629713;
  localparam longint unsigned Q30_ONE    = 64'd1073741824;
  localparam longint unsigned Q30_HALF   = 64'd536870912;
  localparam longint unsigned AMPLITUDE  = 64'd16383;

  typedef struct packed {
    logic [ADDR_W-1:0]   idx0;
    logic [ADDR_W-1:0]   idx1;
    logic [SAMPLE_W-1:0] sample_byte;
    logic                last;
  } q_entry_t;

  // Table entry k: rounded 16383*sin(2*pi*k/TABLE_ENTRIES), Taylor series on the
  // first quadrant in Q30, quadrant symmetry applied after rounding.
  function automatic logic signed [ROM_W-1:0] sin_entry(input int unsigned k);
    logic [PHASE_W-1:0] t;
    logic [1:0]         quad;
    longint unsigned    r;
    longint unsigned    x;
    longint unsigned    term;
    longint unsigned    mag;
    longint unsigned    dv;
    longint unsigned    rem;
    longint unsigned    quo;
    longint             s;
    int unsigned        n;
    int                 b;
    logic [ROM_W-1:0]   m;
    t    = PHASE_W'(k) << (PHASE_W - ADDR_W);
    quad = t[PHASE_W-1 -: 2];
    r    = 64'(t[PHASE_W-3:0]);
    if (quad[0]) begin
      r = Q30_ONE - r;
    end
    x    = (r * HALFPI_Q30 + Q30_HALF) >> 30;
    s    = longint'(x);
    term = x;
    // once a term reaches zero every later one is zero too
    for (n = 1; n < 20; n++) begin
      if (term != 0) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        dv   = 64'(2 * n) * 64'(2 * n + 1);
        // shift-subtract division; the numerator stays below 2^32 here
        rem  = 0;
        quo  = 0;
        for (b = 31; b >= 0; b--) begin
          rem = (rem << 1) | ((term >> b) & 64'd1);
          if (rem >= dv) begin
            rem = rem - dv;
            quo = quo | (64'd1 << b);
          end
        end
        term = quo;
        if (n[0]) begin
          s = s - longint'(term);
        end else begin
          s = s + longint'(term);
        end
      end
    end
    if (s < 0) begin
      s = 0;
    end
    if (s > longint'(Q30_ONE)) begin
      s = longint'(Q30_ONE);
    end
    mag = (longint'(s) * AMPLITUDE + Q30_HALF) >> 30;
    m   = ROM_W'(mag);
    return quad[1] ? -m : m;
  endfunction

endpackage

FILE: sv/ncomi_rom.sv
// Sine/cosine lookup table with registered read data.
module ncomi_rom (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [ncomi_pkg::ADDR_W-1:0]          addr,
  output logic signed [ncomi_pkg::ROM_W-1:0]    sin_val,
  output logic signed [ncomi_pkg::ROM_W-1:0]    cos_val
);

  logic signed [ncomi_pkg::ROM_W-1:0] tab [ncomi_pkg::TABLE_ENTRIES];
  logic signed [ncomi_pkg::ROM_W-1:0] sin_r;
  logic signed [ncomi_pkg::ROM_W-1:0] cos_r;
  logic [ncomi_pkg::ADDR_W-1:0]       cos_addr;

  for (genvar k = 0; k < ncomi_pkg::TABLE_ENTRIES; k++) begin : g_tab
    localparam logic signed [ncomi_pkg::ROM_W-1:0] V = ncomi_pkg::sin_entry(k);
    assign tab[k] = V;
  end

  // cosine is the sine a quarter turn on
  assign cos_addr = addr + ncomi_pkg::ADDR_W'(ncomi_pkg::QUARTER);

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= tab[addr];
      cos_r <= tab[cos_addr];
    end
  end

  assign sin_val = sin_r;
  assign cos_val = cos_r;

endmodule

FILE: sv/ncomi_queue.sv
// Short request queue between the phase front end and the mixing back end.
module ncomi_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ncomi_pkg::q_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output ncomi_pkg::q_entry_t head
);

  ncomi_pkg::q_entry_t                 mem [ncomi_pkg::Q_DEPTH];
  logic [ncomi_pkg::Q_PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [ncomi_pkg::Q_PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [ncomi_pkg::Q_CNT_W-1:0]       count_r, count_nxt;
  logic                                do_push;
  logic                                do_pop;

  assign full      = (count_r == ncomi_pkg::Q_CNT_W'(ncomi_pkg::Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem[rd_ptr_r];

  assign do_push = push && !full;
  assign do_pop  = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

endmodule

FILE: sv/ncomi_front.sv
// Front end: configuration register, request intake and NCO phase stepping.
module ncomi_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ncomi_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [ncomi_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [ncomi_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ncomi_pkg::SAMPLE_W-1:0]      in_sample_byte,
  input  logic                                in_last_of_block,
  input  logic                                q_full,
  output logic                                q_push,
  output ncomi_pkg::q_entry_t                 q_entry
);

  logic [ncomi_pkg::PHASE_W-1:0]   inc_r, inc_nxt;
  logic [ncomi_pkg::PHASE_W-1:0]   phase_r, phase_nxt;
  logic [ncomi_pkg::PHASE_W-1:0]   phase1;
  logic [ncomi_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic                            cfg_wr;
  logic                            accept;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[ncomi_pkg::CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && (cfg_idx == ncomi_pkg::REG_PHASE_INC);

  always_comb begin
    unique case (cfg_idx)
      ncomi_pkg::REG_PHASE_INC: prdata = inc_r;
      default:                  prdata = '0;
    endcase
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;

  // second sample of the byte sits one step on; the byte advances two steps
  assign phase1 = phase_r + inc_r;

  always_comb begin
    q_entry.idx0        = phase_r[ncomi_pkg::PHASE_W-1 -: ncomi_pkg::ADDR_W];
    q_entry.idx1        = phase1[ncomi_pkg::PHASE_W-1 -: ncomi_pkg::ADDR_W];
    q_entry.sample_byte = in_sample_byte;
    q_entry.last        = in_last_of_block;
    phase_nxt = accept ? phase_r + {inc_r[ncomi_pkg::PHASE_W-2:0], 1'b0} : phase_r;
    inc_nxt   = cfg_wr ? pwdata : inc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_r   <= '0;
      phase_r <= '0;
    end else begin
      inc_r   <= inc_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

FILE: sv/ncomi_back.sv
// Back end: table lookup, carrier wipe-off, saturating integration and dump.
module ncomi_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_valid,
  input  ncomi_pkg::q_entry_t                   q_head,
  output logic                                  q_pop,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic signed [ncomi_pkg::OUT_W-1:0]    out_corr_i,
  output logic signed [ncomi_pkg::OUT_W-1:0]    out_corr_q
);

  localparam int DW = ncomi_pkg::DELTA_W;
  localparam int SW = ncomi_pkg::SUM_WIDTH;
  localparam int EW = ncomi_pkg::EDGE_W;

  typedef struct packed {
    logic signed [DW-1:0] di;
    logic signed [DW-1:0] dq;
  } mix_t;

  function automatic logic signed [2:0] comp(input logic mag, input logic sgn);
    logic signed [2:0] v;
    case ({sgn, mag})
      2'b00:   v = 3'sd1;
      2'b01:   v = 3'sd3;
      2'b10:   v = -3'sd1;
      default: v = -3'sd3;
    endcase
    return v;
  endfunction

  // mag/sgn bit 0 is the I component, bit 1 the Q component
  function automatic mix_t mix(input logic [1:0] mag, input logic [1:0] sgn,
                               input logic signed [ncomi_pkg::ROM_W-1:0] c,
                               input logic signed [ncomi_pkg::ROM_W-1:0] s);
    logic signed [2:0]    iv;
    logic signed [2:0]    qv;
    logic signed [DW-1:0] ic;
    logic signed [DW-1:0] i_s;
    logic signed [DW-1:0] qc;
    logic signed [DW-1:0] qs;
    mix_t                 m;
    iv   = comp(mag[0], sgn[0]);
    qv   = comp(mag[1], sgn[1]);
    ic   = DW'(iv) * DW'(c);
    i_s  = DW'(iv) * DW'(s);
    qc   = DW'(qv) * DW'(c);
    qs   = DW'(qv) * DW'(s);
    m.di = ic + qs;
    m.dq = qc - i_s;
    return m;
  endfunction

  // Two saturating adds in a row. The first can only clip when the sum sits
  // within one delta of a rail, which the low bits of the sum decide.
  function automatic logic signed [SW-1:0] sat_step(
      input logic signed [SW-1:0]                a,
      input logic signed [DW-1:0]                d0,
      input logic signed [DW-1:0]                d1,
      input logic signed [ncomi_pkg::DSUM_W-1:0] ds);
    logic signed [EW+1:0] e;
    logic                 near_hi;
    logic                 near_lo;
    logic signed [SW:0]   wide;
    logic signed [SW-1:0] res;
    e       = $signed({2'b00, a[EW-1:0]}) + (EW+2)'(d0);
    near_hi = !a[SW-1] && (&a[SW-2:EW]);
    near_lo = a[SW-1] && !(|a[SW-2:EW]);
    wide    = (SW+1)'(a) + (SW+1)'(ds);
    if (near_hi && !e[EW+1] && e[EW]) begin
      res = (d1 > 0) ? ncomi_pkg::SUM_MAX : ncomi_pkg::SUM_MAX + SW'(d1);
    end else if (near_lo && e[EW+1]) begin
      res = (d1 < 0) ? ncomi_pkg::SUM_MIN : ncomi_pkg::SUM_MIN + SW'(d1);
    end else if (wide[SW] != wide[SW-1]) begin
      res = wide[SW] ? ncomi_pkg::SUM_MIN : ncomi_pkg::SUM_MAX;
    end else begin
      res = wide[SW-1:0];
    end
    return res;
  endfunction

  logic                                 advance;
  logic signed [ncomi_pkg::ROM_W-1:0]   sin0, cos0, sin1, cos1;

  logic                                 s1_valid_r;
  logic                                 s1_last_r;
  logic [ncomi_pkg::SAMPLE_W-1:0]       s1_byte_r;

  mix_t                                 m0, m1;
  logic                                 s2_valid_r;
  logic                                 s2_last_r;
  logic signed [DW-1:0]                 s2_i0_r, s2_i1_r, s2_q0_r, s2_q1_r;
  logic signed [ncomi_pkg::DSUM_W-1:0]  s2_is_r, s2_qs_r;
  logic signed [ncomi_pkg::DSUM_W-1:0]  is_nxt, qs_nxt;

  logic signed [SW-1:0]                 acc_i_r, acc_i_nxt, acc_q_r, acc_q_nxt;
  logic signed [SW-1:0]                 sum_i, sum_q;
  logic signed [ncomi_pkg::OUT_W-1:0]   emit_i, emit_q;
  logic                                 dump;

  logic                                 out_valid_r, out_valid_nxt;
  logic signed [ncomi_pkg::OUT_W-1:0]   out_i_r, out_q_r;

  // hold the whole back end while a finished sum cannot leave
  assign advance = !(s2_valid_r && s2_last_r && out_valid_r && !out_ready);
  assign q_pop   = advance && q_valid;

  ncomi_rom u_rom0 (
    .clk     (clk),
    .en      (advance),
    .addr    (q_head.idx0),
    .sin_val (sin0),
    .cos_val (cos0)
  );

  ncomi_rom u_rom1 (
    .clk     (clk),
    .en      (advance),
    .addr    (q_head.idx1),
    .sin_val (sin1),
    .cos_val (cos1)
  );

  always_comb begin
    m0     = mix({s1_byte_r[1], s1_byte_r[0]}, {s1_byte_r[5], s1_byte_r[4]}, cos0, sin0);
    m1     = mix({s1_byte_r[3], s1_byte_r[2]}, {s1_byte_r[7], s1_byte_r[6]}, cos1, sin1);
    is_nxt = ncomi_pkg::DSUM_W'(m0.di) + ncomi_pkg::DSUM_W'(m1.di);
    qs_nxt = ncomi_pkg::DSUM_W'(m0.dq) + ncomi_pkg::DSUM_W'(m1.dq);
  end

  assign sum_i = sat_step(acc_i_r, s2_i0_r, s2_i1_r, s2_is_r);
  assign sum_q = sat_step(acc_q_r, s2_q0_r, s2_q1_r, s2_qs_r);
  assign dump  = advance && s2_valid_r && s2_last_r;

  if (SW > ncomi_pkg::OUT_W) begin : g_clamp
    localparam logic signed [SW-1:0] OUT_HI =
      {{(SW - ncomi_pkg::OUT_W + 1){1'b0}}, {(ncomi_pkg::OUT_W - 1){1'b1}}};
    localparam logic signed [SW-1:0] OUT_LO = ~OUT_HI;
    always_comb begin
      emit_i = (sum_i > OUT_HI) ? ncomi_pkg::OUT_W'(OUT_HI) :
               (sum_i < OUT_LO) ? ncomi_pkg::OUT_W'(OUT_LO) : ncomi_pkg::OUT_W'(sum_i);
      emit_q = (sum_q > OUT_HI) ? ncomi_pkg::OUT_W'(OUT_HI) :
               (sum_q < OUT_LO) ? ncomi_pkg::OUT_W'(OUT_LO) : ncomi_pkg::OUT_W'(sum_q);
    end
  end else begin : g_ext
    assign emit_i = ncomi_pkg::OUT_W'(sum_i);
    assign emit_q = ncomi_pkg::OUT_W'(sum_q);
  end

  always_comb begin
    acc_i_nxt = acc_i_r;
    acc_q_nxt = acc_q_r;
    if (advance && s2_valid_r) begin
      // clear on the last byte of a block
      acc_i_nxt = s2_last_r ? '0 : sum_i;
      acc_q_nxt = s2_last_r ? '0 : sum_q;
    end
    if (dump) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      acc_i_r     <= '0;
      acc_q_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        s1_valid_r <= q_valid;
        s2_valid_r <= s1_valid_r;
      end
      acc_i_r     <= acc_i_nxt;
      acc_q_r     <= acc_q_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_last_r <= q_head.last;
      s1_byte_r <= q_head.sample_byte;
      s2_last_r <= s1_last_r;
      s2_i0_r   <= m0.di;
      s2_i1_r   <= m1.di;
      s2_is_r   <= is_nxt;
      s2_q0_r   <= m0.dq;
      s2_q1_r   <= m1.dq;
      s2_qs_r   <= qs_nxt;
    end
    if (dump) begin
      out_i_r <= emit_i;
      out_q_r <= emit_q;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_corr_i = out_i_r;
  assign out_corr_q = out_q_r;

endmodule

FILE: sv/nco_mix_and_integrate_unit.sv
// NCO carrier wipe-off with integrate-and-dump, one sample byte per clock.
// Result path: request queue, registered table lookup, mix register, output register.
// Throughput: one byte (two samples) per cycle, set by the two table lookups per sample
// pair and the saturating accumulate; a held result stalls the back end.
// A 4-entry request queue decouples intake from the mixing pipeline.
// Reset (rst_n low, synchronous) clears phase, increment, sums and all valid state.
module nco_mix_and_integrate_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ncomi_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [ncomi_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [ncomi_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ncomi_pkg::SAMPLE_W-1:0]      in_sample_byte,
  input  logic                                in_last_of_block,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ncomi_pkg::OUT_W-1:0]  out_corr_i,
  output logic signed [ncomi_pkg::OUT_W-1:0]  out_corr_q
);

  ncomi_pkg::q_entry_t push_entry;
  ncomi_pkg::q_entry_t head;
  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                q_valid;

  ncomi_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample_byte   (in_sample_byte),
    .in_last_of_block (in_last_of_block),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_entry          (push_entry)
  );

  ncomi_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_valid),
    .head       (head)
  );

  ncomi_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (head),
    .q_pop      (q_pop),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_corr_i (out_corr_i),
    .out_corr_q (out_corr_q)
  );

endmodule

FILE: sv/ncomi_checker.sv
// Port-level checks for the NCO mix and integrate unit, bound to the top level.
module ncomi_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                psel,
  input logic                                penable,
  input logic                                pwrite,
  input logic [ncomi_pkg::CFG_ADDR_W-1:0]    paddr,
  input logic [ncomi_pkg::CFG_DATA_W-1:0]    pwdata,
  input logic [ncomi_pkg::CFG_DATA_W-1:0]    prdata,
  input logic                                pready,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic [ncomi_pkg::SAMPLE_W-1:0]      in_sample_byte,
  input logic                                in_last_of_block,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [ncomi_pkg::OUT_W-1:0]  out_corr_i,
  input logic signed [ncomi_pkg::OUT_W-1:0]  out_corr_q
);

  // reset drops any pending result and leaves the register port ready
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && pready)
    else $error("result pending or port stalled after reset");

  // a written increment reads back on the following cycle
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready && paddr[2] == 1'b0
    |=> paddr[2] != 1'b0 || prdata == $past(pwdata))
    else $error("phase increment does not read back");

  // a waiting request keeps its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready
    |=> in_valid && $stable(in_sample_byte) && $stable(in_last_of_block))
    else $error("request dropped or changed while waiting");

  // a stalled result keeps its sums
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_corr_i) && $stable(out_corr_q))
    else $error("result dropped or changed while stalled");

  // the request queue can only fill up behind a result that is held
  a_backpressure_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("intake stalled with no result waiting");

endmodule

bind nco_mix_and_integrate_unit ncomi_checker u_ncomi_checker (.*);

FILE: tb/tb_nco_mix_and_integrate_unit.sv
// Self-checking testbench for the NCO carrier wipe-off and integrate-and-dump unit.
`timescale 1ns / 1ps

module tb_nco_mix_and_integrate_unit;

  localparam int ROM_SIZE   = ncomi_pkg::TABLE_ENTRIES;
  localparam int ROM_ADDR_W = ncomi_pkg::ADDR_W;
  localparam int OUT_BITS   = ncomi_pkg::OUT_W;
  localparam int ACC_BITS   = ncomi_pkg::SUM_WIDTH;
  localparam longint ACC_TOP    = (64'sd1 <<< (ACC_BITS - 1)) - 1;
  localparam longint ACC_BOTTOM = -ACC_TOP - 1;
  localparam longint OUT_TOP    = (64'sd1 <<< (OUT_BITS - 1)) - 1;
  localparam longint OUT_BOTTOM = -OUT_TOP - 1;

  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30      = 64'd1686629713;
  localparam longint unsigned ROUND_Q30        = 64'd536870912;
  localparam longint unsigned ROM_PEAK         = 64'd16383;

  localparam logic [ncomi_pkg::CFG_ADDR_W-1:0] STEP_ADDR = {ncomi_pkg::REG_PHASE_INC, 2'b00};
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_COUNT  = 8;
  localparam int REQS_PER_PHASE = 125;

  typedef struct packed {
    logic [ncomi_pkg::SAMPLE_W-1:0] data_byte;
    logic                           last;
  } byte_req_t;

  typedef struct {
    logic signed [OUT_BITS-1:0] i;
    logic signed [OUT_BITS-1:0] q;
  } corr_pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                                psel = 1'b0;
  logic                                penable = 1'b0;
  logic                                pwrite = 1'b0;
  logic [ncomi_pkg::CFG_ADDR_W-1:0]    paddr = '0;
  logic [ncomi_pkg::CFG_DATA_W-1:0]    pwdata = '0;
  logic [ncomi_pkg::CFG_DATA_W-1:0]    prdata;
  logic                                pready;

  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic [ncomi_pkg::SAMPLE_W-1:0]      in_sample_byte = '0;
  logic                                in_last_of_block = 1'b0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic signed [OUT_BITS-1:0]          out_corr_i;
  logic signed [OUT_BITS-1:0]          out_corr_q;

  nco_mix_and_integrate_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample_byte   (in_sample_byte),
    .in_last_of_block (in_last_of_block),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_corr_i       (out_corr_i),
    .out_corr_q       (out_corr_q)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // carrier model state
  int          sine_tab [ROM_SIZE];
  int          cosine_tab [ROM_SIZE];
  logic [31:0] step_model;
  logic [31:0] carrier_phase;
  longint      acc_i;
  longint      acc_q;

  byte_req_t  pending_reqs [$];
  corr_pair_t expected_corr [$];
  int         errors = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;

  // Rounded 16383*sin of a phase in turns (Q32): Taylor series on the first quadrant.
  function automatic int taylor_sine(input logic [31:0] turn);
    longint unsigned frac;
    longint unsigned x;
    longint unsigned term;
    longint unsigned mag;
    longint          total;
    int unsigned     n;
    frac = 64'(turn[29:0]);
    if (turn[30]) begin
      frac = QUARTER_TURN_Q30 - frac;
    end
    x     = (frac * HALF_PI_Q30 + ROUND_Q30) >> 30;
    total = longint'(x);
    term  = x;
    n     = 1;
    while (n < 20 && term != 0) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if (n[0]) begin
        total = total - longint'(term);
      end else begin
        total = total + longint'(term);
      end
      n++;
    end
    if (total < 0) begin
      total = 0;
    end
    if (total > longint'(QUARTER_TURN_Q30)) begin
      total = longint'(QUARTER_TURN_Q30);
    end
    mag = (unsigned'(total) * ROM_PEAK + ROUND_Q30) >> 30;
    return turn[31] ? -int'(mag) : int'(mag);
  endfunction

  function automatic longint acc_add(input longint acc, input longint delta);
    longint r;
    r = acc + delta;
    if (r > ACC_TOP) begin
      r = ACC_TOP;
    end
    if (r < ACC_BOTTOM) begin
      r = ACC_BOTTOM;
    end
    return r;
  endfunction

  function automatic logic signed [OUT_BITS-1:0] dump_value(input longint v);
    if (v > OUT_TOP) begin
      v = OUT_TOP;
    end
    if (v < OUT_BOTTOM) begin
      v = OUT_BOTTOM;
    end
    return OUT_BITS'(v);
  endfunction

  // Rotate both samples of a byte by the carrier and integrate; dump on block end.
  function automatic void wipe_off(input byte_req_t req);
    longint                re;
    longint                im;
    longint                c;
    longint                s;
    logic [ROM_ADDR_W-1:0] idx;
    corr_pair_t            pair;
    for (int k = 0; k < 2; k++) begin
      re = req.data_byte[2*k] ? 3 : 1;
      if (req.data_byte[2*k+4]) begin
        re = -re;
      end
      im = req.data_byte[2*k+1] ? 3 : 1;
      if (req.data_byte[2*k+5]) begin
        im = -im;
      end
      idx   = carrier_phase[31 -: ROM_ADDR_W];
      c     = cosine_tab[idx];
      s     = sine_tab[idx];
      acc_i = acc_add(acc_i, re * c + im * s);
      acc_q = acc_add(acc_q, im * c - re * s);
      carrier_phase = carrier_phase + step_model;
    end
    if (req.last) begin
      pair.i = dump_value(acc_i);
      pair.q = dump_value(acc_q);
      expected_corr.push_back(pair);
      acc_i = 0;
      acc_q = 0;
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    byte_req_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        wipe_off(byte_req_t'({in_sample_byte, in_last_of_block}));
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req = pending_reqs.pop_front();
          in_valid         <= 1'b1;
          in_sample_byte   <= req.data_byte;
          in_last_of_block <= req.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    corr_pair_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_corr.size() == 0) begin
          $display("%0t: unexpected result i=%0d q=%0d", $time, out_corr_i, out_corr_q);
          errors++;
        end else begin
          want = expected_corr.pop_front();
          if (out_corr_i !== want.i) begin
            $display("%0t: corr_i expected %0d, got %0d", $time, want.i, out_corr_i);
            errors++;
          end
          if (out_corr_q !== want.q) begin
            $display("%0t: corr_q expected %0d, got %0d", $time, want.q, out_corr_q);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Write the phase step, then read it back.
  task automatic program_step(input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= STEP_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    step_model = value;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== value) begin
      $display("%0t: phase step readback expected %h, got %h", $time, value, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Wait until every request is taken and every sum has come back, then let the pipe empty.
  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || expected_corr.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [31:0] steps [PHASE_COUNT];
    logic [8:0]  opening [20];
    byte_req_t   req;
    int          count;
    int          len;

    for (int k = 0; k < ROM_SIZE; k++) begin
      sine_tab[k]   = taylor_sine(32'(k) << (32 - ROM_ADDR_W));
      cosine_tab[k] = taylor_sine((32'(k) << (32 - ROM_ADDR_W)) + 32'h4000_0000);
    end
    step_model    = '0;
    carrier_phase = '0;
    acc_i         = 0;
    acc_q         = 0;

    steps = '{32'h2000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000,
              32'h0000_0001, $urandom, 32'h7FFF_FFFF, $urandom};
    // bit 8 marks the end of a block
    opening = '{9'h100, 9'h1FF, 9'h00F, 9'h1F0, 9'h055, 9'h0AA, 9'h033, 9'h1CC,
                9'h011, 9'h022, 9'h044, 9'h088, 9'h0FF, 9'h0FF, 9'h1FF, 9'h15A,
                9'h1A5, 9'h03C, 9'h0C3, 9'h100};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 86;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 86;
        end
        default: begin
          send_idle_pct  = 30;
          recv_stall_pct = 30;
        end
      endcase
      program_step(steps[p]);
      @(negedge clk);
      if (p == 0) begin
        foreach (opening[k]) begin
          req.data_byte = opening[k][7:0];
          req.last      = opening[k][8];
          pending_reqs.push_back(req);
        end
      end
      count = 0;
      while (count < REQS_PER_PHASE) begin
        // mostly short blocks, now and then a long one
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
          req.data_byte = ncomi_pkg::SAMPLE_W'($urandom);
          req.last      = (k == len - 1);
          pending_reqs.push_back(req);
        end
        count += len;
      end
      drain();
    end

    if (errors == 0) begin
      $display("tb_nco_mix_and_integrate_unit passed");
    end else begin
      $display("tb_nco_mix_and_integrate_unit failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_nco_mix_and_integrate_unit failed");
    $finish;
  end

endmodule
